// ----- src/min_heap_timer_queue_macros.svh -----
// Assertion macros for the timer queue checker.
// Used by min_heap_timer_queue_chk.sv; holds nothing but macro definitions.
`ifndef MIN_HEAP_TIMER_QUEUE_MACROS_SVH
`define MIN_HEAP_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MHTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MHTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mhtq_pkg.sv -----
// Shared types, codes and helpers for the min-heap timer queue.
// No dependencies; used by the top level and its checker.
package mhtq_pkg;

    localparam int HEAP_DEPTH = 32;
    localparam int ID_COUNT   = 256;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int IDV_W      = $clog2(ID_COUNT);

    // Command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_ADJUST = 3'd1;
    localparam logic [2:0] CMD_FIRE   = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;

    // Result kinds
    localparam logic [2:0] KIND_DONE    = 3'd0;
    localparam logic [2:0] KIND_EXPIRED = 3'd1;
    localparam logic [2:0] KIND_NEXT    = 3'd2;
    localparam logic [2:0] KIND_EMPTY   = 3'd3;
    localparam logic [2:0] KIND_FULL    = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;

    localparam logic [23:0] LEFT_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic [31:0] dl;
        logic [7:0]  owner;
    } heap_ent_t;

    // Wrapping deadline order: a before b
    function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    // Deadline reached at time now
    function automatic logic is_due(input logic [31:0] d, input logic [31:0] now);
        logic [31:0] diff;
        diff = d - now;
        return (diff == 32'd0) || diff[31];
    endfunction

endpackage

// ----- src/min_heap_timer_queue.sv -----
// Timer queue top level: heap memory, id-to-slot memory and sequencer.
// Depends on mhtq_pkg.
//
// Usage: drive cmd, timer_id and timeout_ms with start high; the item is
// taken at a rising edge where start is high and busy is low. busy drops in
// the cycle that shows the item's last result. Results come one per
// cycle at most on kind, out_id, time_left, live_count and last, each for
// exactly one cycle with out_valid high; last marks the final result of an
// item. The receiver cannot stall, so results are never held.
// An item runs through dispatch and then its heap walk. Every step of the walk
// uses the single heap read port. Moving up reads the parent and compares;
// moving down reads the left child, then the right child, then compares.
// Tick and query check the root and do one sift-down for every expired
// timer.
// One item at a time.
// Reset clears the clock, the timer count and every id mapping; heap slots
// hold no meaning until written.
module min_heap_timer_queue
    import mhtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  timer_id,
    input  logic [23:0] timeout_ms,
    output logic        out_valid,
    output logic [2:0]  kind,
    output logic [7:0]  out_id,
    output logic [23:0] time_left,
    output logic [5:0]  live_count,
    output logic        last
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DN, S_DN_L, S_DN_R, S_DN_CMP, S_DN_END,
        S_UP, S_UP_CMP, S_PLACE, S_LASTRD, S_LASTGET, S_EXP, S_EXPCHK, S_QFIN
    } state_t;

    // Memories
    heap_ent_t        heap_mem [HEAP_DEPTH];
    logic [IDX_W-1:0] slot_mem [ID_COUNT];

    heap_ent_t        heap_q;
    logic [IDX_W-1:0] slot_q;

    state_t           state_reg;
    logic [2:0]       cmd_reg;
    logic [7:0]       id_reg;
    logic [23:0]      tmo_reg;
    logic [31:0]      now_reg;
    logic [CNT_W-1:0] count_reg;
    logic [ID_COUNT-1:0] valid_reg;
    heap_ent_t        e_reg;
    heap_ent_t        cand_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] start_reg;
    logic [IDX_W-1:0] cidx_reg;
    logic             post_exp_reg;
    logic [7:0]       res_id_reg;
    logic             pend_reg;
    logic [7:0]       pend_id_reg;
    logic [CNT_W-1:0] pend_cnt_reg;
    logic [2:0]       fin_kind_reg;
    logic [23:0]      fin_left_reg;

    logic             out_valid_reg;
    logic [2:0]       kind_reg;
    logic [7:0]       out_id_reg;
    logic [23:0]      time_left_reg;
    logic [5:0]       live_count_reg;
    logic             last_reg;

    // Heap walk addressing
    logic [IDX_W+1:0] c_left;
    logic [IDX_W+1:0] c_right;
    logic [IDX_W-1:0] parent;
    logic [IDX_W-1:0] heap_raddr;
    logic             heap_we;
    logic [IDX_W-1:0] heap_waddr;
    heap_ent_t        heap_wdata;
    logic             slot_we;
    logic [IDV_W-1:0] slot_waddr;
    logic [IDX_W-1:0] slot_wdata;
    logic             known;
    logic [31:0]      new_dl;
    logic [31:0]      diff_now;

    assign c_left   = {1'b0, i_reg, 1'b1};
    assign c_right  = {1'b0, i_reg, 1'b0} + (IDX_W+2)'(2);
    assign parent   = (i_reg - IDX_W'(1)) >> 1;
    assign known    = valid_reg[id_reg];
    assign new_dl   = now_reg + {8'd0, tmo_reg};
    assign diff_now = heap_q.dl - now_reg;

    // Heap read address per state
    always_comb
    begin
        case (state_reg)
            S_DN:     heap_raddr = c_left[IDX_W-1:0];
            S_DN_L:   heap_raddr = c_right[IDX_W-1:0];
            S_UP:     heap_raddr = parent;
            S_LASTRD: heap_raddr = count_reg[IDX_W-1:0];
            default:  heap_raddr = '0;
        endcase
    end

    // Heap and map writes: one move per cycle
    always_comb
    begin
        heap_we    = 1'b0;
        heap_waddr = i_reg;
        heap_wdata = e_reg;
        slot_we    = 1'b0;
        slot_waddr = e_reg.owner;
        slot_wdata = i_reg;
        case (state_reg)
            S_DN_CMP:
            begin
                if (earlier(cand_reg.dl, e_reg.dl))
                begin
                    heap_we    = 1'b1;
                    heap_wdata = cand_reg;
                    slot_we    = 1'b1;
                    slot_waddr = cand_reg.owner;
                end
            end
            S_UP_CMP:
            begin
                if (earlier(e_reg.dl, heap_q.dl))
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_q;
                    slot_we    = 1'b1;
                    slot_waddr = heap_q.owner;
                end
            end
            S_PLACE:
            begin
                heap_we = 1'b1;
                slot_we = 1'b1;
            end
            default:
            begin
                heap_we = 1'b0;
            end
        endcase
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_waddr] <= heap_wdata;
        heap_q <= heap_mem[heap_raddr];
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_q <= slot_mem[timer_id];
    end

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_DONE;
            out_id_reg     <= '0;
            time_left_reg  <= '0;
            last_reg       <= 1'b0;
            live_count_reg <= count_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        id_reg    <= timer_id;
                        tmo_reg   <= timeout_ms;
                        pend_reg  <= 1'b0;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    post_exp_reg <= 1'b0;
                    res_id_reg   <= '0;
                    start_reg    <= slot_q;
                    i_reg        <= slot_q;
                    e_reg.dl     <= new_dl;
                    e_reg.owner  <= id_reg;
                    case (cmd_reg)
                        CMD_ADD, CMD_ADJUST:
                        begin
                            if (known)
                                state_reg <= S_DN;
                            else if (cmd_reg == CMD_ADJUST || count_reg == CNT_W'(HEAP_DEPTH))
                            begin
                                out_valid_reg <= 1'b1;
                                kind_reg      <= (cmd_reg == CMD_ADJUST) ? KIND_UNKNOWN
                                                                        : KIND_FULL;
                                last_reg      <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                            else
                            begin
                                i_reg             <= count_reg[IDX_W-1:0];
                                count_reg         <= count_reg + CNT_W'(1);
                                valid_reg[id_reg] <= 1'b1;
                                state_reg         <= S_UP;
                            end
                        end
                        CMD_FIRE:
                        begin
                            if (!known)
                            begin
                                out_valid_reg <= 1'b1;
                                kind_reg      <= KIND_UNKNOWN;
                                last_reg      <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                            else
                            begin
                                valid_reg[id_reg] <= 1'b0;
                                count_reg         <= count_reg - CNT_W'(1);
                                res_id_reg        <= id_reg;
                                if ({1'b0, slot_q} < count_reg - CNT_W'(1))
                                    state_reg <= S_LASTRD;
                                else
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_id_reg     <= id_reg;
                                    live_count_reg <= count_reg - CNT_W'(1);
                                    last_reg       <= 1'b1;
                                    state_reg      <= S_IDLE;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            now_reg   <= now_reg + 32'd1;
                            state_reg <= S_EXP;
                        end
                        CMD_QUERY:
                        begin
                            state_reg <= S_EXP;
                        end
                        default:
                        begin
                            out_valid_reg <= 1'b1;
                            last_reg      <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    endcase
                end
                // Sift down: fetch left child, then right child
                S_DN:
                begin
                    if (c_left >= (IDX_W+2)'(count_reg))
                        state_reg <= S_DN_END;
                    else
                        state_reg <= S_DN_L;
                end
                S_DN_L:
                begin
                    cand_reg <= heap_q;
                    cidx_reg <= c_left[IDX_W-1:0];
                    if (c_right < (IDX_W+2)'(count_reg))
                        state_reg <= S_DN_R;
                    else
                        state_reg <= S_DN_CMP;
                end
                S_DN_R:
                begin
                    if (earlier(heap_q.dl, cand_reg.dl))
                    begin
                        cand_reg <= heap_q;
                        cidx_reg <= c_right[IDX_W-1:0];
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (earlier(cand_reg.dl, e_reg.dl))
                    begin
                        i_reg     <= cidx_reg;
                        state_reg <= S_DN;
                    end
                    else
                        state_reg <= S_DN_END;
                end
                S_DN_END:
                begin
                    state_reg <= (i_reg != start_reg) ? S_PLACE : S_UP;
                end
                // Sift up: fetch parent, move it down while the item is earlier
                S_UP:
                begin
                    state_reg <= (i_reg == '0) ? S_PLACE : S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (earlier(e_reg.dl, heap_q.dl))
                    begin
                        i_reg     <= parent;
                        state_reg <= S_UP;
                    end
                    else
                        state_reg <= S_PLACE;
                end
                S_PLACE:
                begin
                    if (post_exp_reg)
                        state_reg <= S_EXP;
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= res_id_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                // Move the last slot into the hole
                S_LASTRD:
                begin
                    state_reg <= S_LASTGET;
                end
                S_LASTGET:
                begin
                    e_reg     <= heap_q;
                    state_reg <= S_DN;
                end
                S_EXP:
                begin
                    state_reg <= S_EXPCHK;
                end
                // Root check; one expired result is held back to learn if it is last
                S_EXPCHK:
                begin
                    if (count_reg != '0 && is_due(heap_q.dl, now_reg))
                    begin
                        if (pend_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            kind_reg       <= KIND_EXPIRED;
                            out_id_reg     <= pend_id_reg;
                            live_count_reg <= pend_cnt_reg;
                        end
                        pend_reg                <= 1'b1;
                        pend_id_reg             <= heap_q.owner;
                        pend_cnt_reg            <= count_reg - CNT_W'(1);
                        valid_reg[heap_q.owner] <= 1'b0;
                        count_reg               <= count_reg - CNT_W'(1);
                        i_reg                   <= '0;
                        start_reg               <= '0;
                        post_exp_reg            <= 1'b1;
                        state_reg <= (count_reg > CNT_W'(1)) ? S_LASTRD : S_EXP;
                    end
                    else if (cmd_reg == CMD_TICK)
                    begin
                        out_valid_reg <= 1'b1;
                        last_reg      <= 1'b1;
                        if (pend_reg)
                        begin
                            kind_reg       <= KIND_EXPIRED;
                            out_id_reg     <= pend_id_reg;
                            live_count_reg <= pend_cnt_reg;
                        end
                        pend_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        fin_kind_reg <= (count_reg == '0) ? KIND_EMPTY : KIND_NEXT;
                        if (count_reg == '0)
                            fin_left_reg <= '0;
                        else if (diff_now > {8'd0, LEFT_MAX})
                            fin_left_reg <= LEFT_MAX;
                        else
                            fin_left_reg <= diff_now[23:0];
                        if (pend_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            kind_reg       <= KIND_EXPIRED;
                            out_id_reg     <= pend_id_reg;
                            live_count_reg <= pend_cnt_reg;
                            state_reg      <= S_QFIN;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            last_reg      <= 1'b1;
                            kind_reg      <= (count_reg == '0) ? KIND_EMPTY : KIND_NEXT;
                            if (count_reg == '0)
                                time_left_reg <= '0;
                            else if (diff_now > {8'd0, LEFT_MAX})
                                time_left_reg <= LEFT_MAX;
                            else
                                time_left_reg <= diff_now[23:0];
                            state_reg <= S_IDLE;
                        end
                        pend_reg <= 1'b0;
                    end
                end
                S_QFIN:
                begin
                    out_valid_reg <= 1'b1;
                    kind_reg      <= fin_kind_reg;
                    time_left_reg <= fin_left_reg;
                    last_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign out_id     = out_id_reg;
    assign time_left  = time_left_reg;
    assign live_count = live_count_reg;
    assign last       = last_reg;

endmodule

// ----- src/min_heap_timer_queue_chk.sv -----
// Port-level checker for the timer queue, bound to the top level.
// Depends on mhtq_pkg and min_heap_timer_queue_macros.svh.
`include "min_heap_timer_queue_macros.svh"

module mhtq_chk
    import mhtq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        out_valid,
    input logic [2:0]  kind,
    input logic [23:0] time_left,
    input logic [5:0]  live_count,
    input logic        last
);

    `MHTQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `MHTQ_ASSERT_NEXT(a_last_gap, out_valid && last, !out_valid, "result right after last")
    `MHTQ_ASSERT_NOW(a_left_zero, out_valid && kind != KIND_NEXT, time_left == '0, "stray time_left")
    `MHTQ_ASSERT_NOW(a_mid_expired, out_valid && !last, kind == KIND_EXPIRED, "non-final result not expired")
    `MHTQ_ASSERT_NOW(a_empty_count, out_valid && kind == KIND_EMPTY, live_count == '0, "empty with timers")

endmodule

bind min_heap_timer_queue mhtq_chk u_mhtq_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_valid  (out_valid),
    .kind       (kind),
    .time_left  (time_left),
    .live_count (live_count),
    .last       (last)
);
